// ----- hdl/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

	// Status of the shared modular multiplier, as seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// Sequencer state codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RED  = 2'd1;
	localparam logic [1:0] S_SQR  = 2'd2;
	localparam logic [1:0] S_MUL  = 2'd3;

endpackage

// ----- hdl/modular_exponentiation_top.sv -----
// Modular exponentiation top level: square-and-multiply sequencer around one modular multiplier.
// An item is taken when start is high and busy is low. Busy then stays high until the result is
// shown. A zero modulus never raises busy. Each modular product runs bit-serially through one
// shared multiplier, one bit of the multiplier operand per cycle. An item takes one product to
// reduce the base, plus one squaring per exponent bit and one multiply per set exponent bit.
// A zero modulus is answered in the next cycle with bad_modulus set. The result is marked by
// done, which is high for a single cycle; power_mod and bad_modulus hold it until the next item
// is taken. The receiver cannot stall it, so it must take it in that cycle.
module modular_exponentiation_top #(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OPERAND_WIDTH-1:0] base,
	input  logic [OPERAND_WIDTH-1:0] exponent,
	input  logic [OPERAND_WIDTH-1:0] modulus,
	output logic                     done,
	output logic [OPERAND_WIDTH-1:0] power_mod,
	output logic                     bad_modulus
);

	localparam int W  = OPERAND_WIDTH;
	localparam int KW = $clog2(W);

	logic [1:0]    state_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  exp_q;
	logic [W-1:0]  mod_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  op_a_q;
	logic [W-1:0]  op_b_q;
	logic          go_q;
	logic          done_q;
	logic [W-1:0]  result_q;
	logic          bad_q;

	mexp_pkg::mul_stat_t mul_stat;
	logic [W-1:0]        prod;

	mexp_mulmod #(
		.W(W)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go_q),
		.a     (op_a_q),
		.b     (op_b_q),
		.m     (mod_q),
		.stat  (mul_stat),
		.prod  (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::S_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				mexp_pkg::S_IDLE: begin
					if (start) begin
						if (modulus == '0) begin
							done_q <= 1'b1;
						end else begin
							go_q    <= 1'b1;
							state_q <= mexp_pkg::S_RED;
						end
					end
				end
				mexp_pkg::S_RED: begin
					if (mul_stat.done) begin
						go_q    <= 1'b1;
						state_q <= mexp_pkg::S_SQR;
					end
				end
				mexp_pkg::S_SQR: begin
					if (mul_stat.done) begin
						if (exp_q[W-1]) begin
							go_q    <= 1'b1;
							state_q <= mexp_pkg::S_MUL;
						end else if (k_q == '0) begin
							done_q  <= 1'b1;
							state_q <= mexp_pkg::S_IDLE;
						end else begin
							go_q <= 1'b1;
						end
					end
				end
				mexp_pkg::S_MUL: begin
					if (mul_stat.done) begin
						if (k_q == '0) begin
							done_q  <= 1'b1;
							state_q <= mexp_pkg::S_IDLE;
						end else begin
							go_q    <= 1'b1;
							state_q <= mexp_pkg::S_SQR;
						end
					end
				end
				default: begin
					state_q <= mexp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Operand and data path; the multiplier latches op_a_q/op_b_q when go_q is high
	always_ff @(posedge clk) begin
		unique case (state_q)
			mexp_pkg::S_IDLE: begin
				if (start) begin
					exp_q    <= exponent;
					mod_q    <= modulus;
					op_a_q   <= W'(1);
					op_b_q   <= base;
					k_q      <= KW'(W - 1);
					result_q <= '0;
					bad_q    <= (modulus == '0);
				end
			end
			mexp_pkg::S_RED: begin
				if (mul_stat.done) begin
					base_q <= prod;
					// square the starting value, 1 mod m
					op_a_q <= (mod_q == W'(1)) ? '0 : W'(1);
					op_b_q <= (mod_q == W'(1)) ? '0 : W'(1);
				end
			end
			mexp_pkg::S_SQR: begin
				if (mul_stat.done) begin
					result_q <= prod;
					if (exp_q[W-1]) begin
						op_a_q <= base_q;
						op_b_q <= prod;
					end else if (k_q != '0) begin
						k_q    <= k_q - 1'b1;
						exp_q  <= {exp_q[W-2:0], 1'b0};
						op_a_q <= prod;
						op_b_q <= prod;
					end
				end
			end
			mexp_pkg::S_MUL: begin
				if (mul_stat.done) begin
					result_q <= prod;
					if (k_q != '0) begin
						k_q    <= k_q - 1'b1;
						exp_q  <= {exp_q[W-2:0], 1'b0};
						op_a_q <= prod;
						op_b_q <= prod;
					end
				end
			end
			default: begin
				result_q <= '0;
			end
		endcase
	end

	assign busy        = (state_q != mexp_pkg::S_IDLE);
	assign done        = done_q;
	assign power_mod   = result_q;
	assign bad_modulus = bad_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_modulus |-> power_mod == '0)
		else $error("error result is not zero");

	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && modulus == '0 |=> done && bad_modulus)
		else $error("zero modulus not answered at once");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !bad_modulus |-> power_mod < mod_q)
		else $error("result not reduced by the modulus");

	a_go_free: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !mul_stat.busy && busy)
		else $error("multiplier launched while running or idle");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> state_q != mexp_pkg::S_IDLE)
		else $error("product finished with the sequencer idle");

endmodule

// ----- hdl/mexp_mulmod.sv -----
// Bit-serial shift-and-add modular multiplier: one bit of b per cycle.
module mexp_mulmod #(
	parameter int W = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	input  logic [W-1:0]        m,
	output mexp_pkg::mul_stat_t stat,
	output logic [W-1:0]        prod
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  m_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [W:0]   dbl_sum;
	logic [W-1:0] dbl_red;
	logic [W:0]   add_sum;
	logic [W-1:0] add_red;
	logic [W-1:0] acc_next;

	// Double the accumulator, then add a when the current bit of b is set; reduce after each
	always_comb begin
		dbl_sum = {1'b0, acc_q} + {1'b0, acc_q};
		if (dbl_sum >= {1'b0, m_q}) begin
			dbl_red = W'(dbl_sum - {1'b0, m_q});
		end else begin
			dbl_red = dbl_sum[W-1:0];
		end
		add_sum = {1'b0, dbl_red} + {1'b0, a_q};
		if (add_sum >= {1'b0, m_q}) begin
			add_red = W'(add_sum - {1'b0, m_q});
		end else begin
			add_red = add_sum[W-1:0];
		end
		acc_next = b_q[W-1] ? add_red : dbl_red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (run_q) begin
			acc_q <= acc_next;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

// ----- verif/modular_exponentiation_top_tb.sv -----
// Testbench for modular_exponentiation_top: directed and random items checked against a predictor.
`timescale 1ns / 100ps

// Holds the expected power_mod results in arrival order and checks each one as it comes out.
class power_mod_board #(int WIDTH = 31);

	typedef struct {
		bit [WIDTH-1:0] base;
		bit [WIDTH-1:0] exponent;
		bit [WIDTH-1:0] modulus;
		bit [WIDTH-1:0] value;
		bit             bad;
	} power_t;

	power_t expected_powers[$];

	// Square and multiply over every exponent bit, reducing each product at once
	function power_t predict_power_mod(bit [WIDTH-1:0] b, bit [WIDTH-1:0] e, bit [WIDTH-1:0] m);
		power_t    p;
		bit [63:0] acc;
		bit [63:0] red;
		p.base = b;
		p.exponent = e;
		p.modulus = m;
		if (m == 0) begin
			p.value = '0;
			p.bad = 1'b1;
			return p;
		end
		red = 64'(b % m);
		acc = 64'(1 % m);
		for (int k = WIDTH - 1; k >= 0; k--) begin
			acc = (acc * acc) % m;
			if (e[k])
				acc = (acc * red) % m;
		end
		p.value = acc[WIDTH-1:0];
		p.bad = 1'b0;
		return p;
	endfunction

	function void note_item(bit [WIDTH-1:0] b, bit [WIDTH-1:0] e, bit [WIDTH-1:0] m);
		expected_powers.push_back(predict_power_mod(b, e, m));
	endfunction

	// Empty string when the result matches the oldest expectation
	function string check_result(bit [WIDTH-1:0] value, bit bad);
		power_t p;
		if (expected_powers.size() == 0)
			return $sformatf("result %0d bad_modulus %0b with no item outstanding", value, bad);
		p = expected_powers.pop_front();
		if (value !== p.value || bad !== p.bad)
			return $sformatf("%0d^%0d mod %0d: power_mod %0d (want %0d), bad_modulus %0b (want %0b)",
				p.base, p.exponent, p.modulus, value, p.value, bad, p.bad);
		return "";
	endfunction

	function int pending();
		return expected_powers.size();
	endfunction

endclass

module modular_exponentiation_top_tb;

	localparam int W            = 31;
	localparam int HALF_PERIOD  = 6;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 2100;
	localparam int RANDOM_ITEMS = 272;
	localparam int DIRECTED     = 18;
	localparam logic [W-1:0] MAXV = {W{1'b1}};

	logic         clk         = 1'b0;
	logic         arst_n      = 1'b0;
	logic         start       = 1'b0;
	logic [W-1:0] base        = '0;
	logic [W-1:0] exponent    = '0;
	logic [W-1:0] modulus     = '0;
	logic         busy;
	logic         done;
	logic [W-1:0] power_mod;
	logic         bad_modulus;

	power_mod_board #(W) board;
	int    mismatches  = 0;
	int    cycle_count = 0;
	bit    no_idle     = 1'b0;
	string verdict;

	modular_exponentiation_top #(.OPERAND_WIDTH(W)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.base        (base),
		.exponent    (exponent),
		.modulus     (modulus),
		.done        (done),
		.power_mod   (power_mod),
		.bad_modulus (bad_modulus)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[modular_exponentiation_top] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Results last one cycle: take them at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done) begin
			verdict = board.check_result(power_mod, bad_modulus);
			if (verdict != "")
				report_mismatch(verdict);
		end
	end

	task automatic send_item(input logic [W-1:0] b, input logic [W-1:0] e, input logic [W-1:0] m);
		int gap;
		bit wait_idle;
		gap = 0;
		wait_idle = 1'b0;
		if (!no_idle) begin
			while ($urandom_range(99) < 31)
				gap++;
			wait_idle = ($urandom_range(99) < 8);
		end
		if (wait_idle && gap == 0)
			gap = 1;
		if (gap != 0) begin
			start <= 1'b0;
			// Let some gaps land on an idle block, not only on a busy one
			if (wait_idle)
				while (busy)
					@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		base     <= b;
		exponent <= e;
		modulus  <= m;
		do
			@(posedge clk);
		while (busy);
		board.note_item(b, e, m);
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	logic [W-1:0] dir_base [DIRECTED] = '{
		31'd5, MAXV, MAXV, 31'd7, MAXV - 31'd1, 31'd0, 31'd0, MAXV, MAXV,
		31'd3, 31'd2, MAXV - 31'd1, 31'd12345, 31'd4, 31'd7, 31'd3, 31'h4000_0000, 31'h5555_5555
	};
	logic [W-1:0] dir_exp [DIRECTED] = '{
		31'd3, MAXV, MAXV, 31'd0, 31'd0, 31'd0, 31'd5, MAXV, MAXV,
		MAXV, 31'd30, 31'd2, 31'd1, 31'd13, MAXV - 31'd1, 31'h4000_0000, 31'd1, 31'h2AAA_AAAA
	};
	logic [W-1:0] dir_mod [DIRECTED] = '{
		31'd0, 31'd0, MAXV, 31'd1, MAXV, 31'd13, 31'd13, MAXV - 31'd1, 31'd1,
		31'd2, MAXV, MAXV, 31'd1000, 31'd497, MAXV, 31'h4000_0000, 31'd3, 31'h2AAA_AAAB
	};

	initial begin
		logic [W-1:0] b;
		logic [W-1:0] e;
		logic [W-1:0] m;
		int           pick;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIRECTED; i++)
			send_item(dir_base[i], dir_exp[i], dir_mod[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				drain_results();
			no_idle = (i >= 120 && i < 180);
			b = W'($urandom());
			e = W'($urandom());
			m = W'($urandom());
			pick = $urandom_range(99);
			if (pick < 8)
				m = '0;
			else if (pick < 18)
				m = W'($urandom_range(16, 1));
			else if (pick < 25)
				e = W'($urandom_range(3, 0));
			else if (pick < 30)
				e = MAXV;
			if ($urandom_range(99) < 20)
				b = W'($urandom_range(20, 0));
			send_item(b, e, m);
		end

		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[modular_exponentiation_top] OK");
		else
			$display("[modular_exponentiation_top] ERROR");
		$finish;
	end

endmodule
